>>> design/hbk_pkg.sv
// Shared types, constants and the US layout usage-to-character function.
package hbk_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int STORE_DEPTH = 6;
    localparam int SLOT_CNT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int REC_CNT_W   = $clog2(STORE_DEPTH + 1);

    localparam logic [7:0] SHIFT_MASK  = 8'h22;
    localparam logic [7:0] CODE_NONE   = 8'hFF;
    localparam logic [7:0] CODE_ERASE  = 8'h7F;
    localparam logic [7:0] USAGE_LIMIT = 8'd101;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic flush;
    } hbk_cmd_t;

    typedef struct packed {
        logic emit;
        logic pend_valid;
        logic out_free;
    } hbk_sts_t;

    localparam byte_t DIGITS_PLAIN [10] = '{
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30
    };
    localparam byte_t DIGITS_SHIFT [10] = '{
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29
    };
    localparam byte_t CTRL_CODES [5] = '{
        8'h0A, 8'h1B, CODE_ERASE, 8'h09, 8'h20
    };
    localparam byte_t PUNCT_PLAIN [12] = '{
        8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, CODE_NONE,
        8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F
    };
    localparam byte_t PUNCT_SHIFT [12] = '{
        8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, CODE_NONE,
        8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F
    };
    localparam byte_t KEYPAD_CODES [15] = '{
        8'h2A, 8'h2D, 8'h2B, 8'h0A, 8'h31, 8'h32, 8'h33, 8'h34,
        8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2E
    };

    // Maps a usage below 128 to its US layout character, CODE_NONE if unmapped.
    function automatic byte_t map_usage(input logic [6:0] u, input logic shift);
        logic [6:0] off;
        byte_t      res;
        off = 7'd0;
        res = CODE_NONE;
        if (u >= 7'd4 && u <= 7'd29) begin
            off = u - 7'd4;
            res = (shift ? 8'h41 : 8'h61) + {1'b0, off};
        end else if (u >= 7'd30 && u <= 7'd39) begin
            off = u - 7'd30;
            res = shift ? DIGITS_SHIFT[off[3:0]] : DIGITS_PLAIN[off[3:0]];
        end else if (u >= 7'd40 && u <= 7'd44) begin
            off = u - 7'd40;
            res = CTRL_CODES[off[2:0]];
        end else if (u >= 7'd45 && u <= 7'd56) begin
            off = u - 7'd45;
            res = shift ? PUNCT_SHIFT[off[3:0]] : PUNCT_PLAIN[off[3:0]];
        end else if (u >= 7'd85 && u <= 7'd99) begin
            off = u - 7'd85;
            res = KEYPAD_CODES[off[3:0]];
        end else if (u == 7'd100) begin
            res = shift ? 8'hB1 : 8'hA7;
        end
        return res;
    endfunction

endpackage

>>> design/hbk_ctrl.sv
// Controller state machine: sequences capture, slot scan, store update and final flush.
module hbk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hbk_pkg::hbk_sts_t sts,
    output hbk_pkg::hbk_cmd_t cmd
);
    import hbk_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SLOT_CNT_W-1:0] slot_reg, slot_next;
    logic                  stall;

    assign in_ready = (state_reg == ST_IDLE);
    // A new character cannot be taken while one is pending and the output is full.
    assign stall    = sts.emit && sts.pend_valid && !sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    slot_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    cmd.step = 1'b1;
                    if (slot_reg == SLOT_CNT_W'(KEY_SLOTS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.commit = 1'b1;
                if (!sts.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

>>> design/hbk_datapath.sv
// Datapath: report capture, held-key check, layout mapping, pending and output registers.
module hbk_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  hbk_pkg::hbk_cmd_t cmd,
    output hbk_pkg::hbk_sts_t sts,
    input  logic [7:0]        modifier_bits,
    input  logic [7:0]        key_slot_0,
    input  logic [7:0]        key_slot_1,
    input  logic [7:0]        key_slot_2,
    input  logic [7:0]        key_slot_3,
    input  logic [7:0]        key_slot_4,
    input  logic [7:0]        key_slot_5,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        char_code,
    output logic [6:0]        usage_code,
    output logic              last_of_report
);
    import hbk_pkg::*;

    byte_t                slots_in  [6];
    byte_t                slots_reg [KEY_SLOTS];
    byte_t                prev_reg  [STORE_DEPTH];
    byte_t                rec_reg   [STORE_DEPTH];
    logic [REC_CNT_W-1:0] rec_cnt_reg;
    logic                 shift_reg;

    logic                 pend_valid_reg;
    byte_t                pend_char_reg;
    logic [6:0]           pend_usage_reg;

    logic                 out_valid_reg;
    byte_t                out_char_reg;
    logic [6:0]           out_usage_reg;
    logic                 out_last_reg;

    byte_t                cur;
    logic                 usage_ok;
    logic                 held;
    byte_t                cur_char;
    logic                 out_free;

    assign slots_in[0] = key_slot_0;
    assign slots_in[1] = key_slot_1;
    assign slots_in[2] = key_slot_2;
    assign slots_in[3] = key_slot_3;
    assign slots_in[4] = key_slot_4;
    assign slots_in[5] = key_slot_5;

    assign cur      = slots_reg[0];
    assign usage_ok = (cur != 8'd0) && (cur < USAGE_LIMIT);
    assign cur_char = map_usage(cur[6:0], shift_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        held = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (prev_reg[i] == cur)
            begin
                held = 1'b1;
            end
        end
    end

    assign sts.emit       = usage_ok && !held && (cur_char != CODE_NONE);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    // Report capture and slot shifter; the current slot is always entry zero.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            shift_reg <= (modifier_bits & SHIFT_MASK) != 8'd0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                slots_reg[i] <= slots_in[i];
            end
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < KEY_SLOTS - 1; i++)
            begin
                slots_reg[i] <= slots_reg[i + 1];
            end
            slots_reg[KEY_SLOTS - 1] <= 8'd0;
        end
    end

    // Recorded usages of the current report, compacted and zero padded, copied to the previous-key store on commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_cnt_reg <= '0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                rec_reg[i]  <= 8'd0;
                prev_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                rec_cnt_reg <= '0;
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    rec_reg[i] <= 8'd0;
                end
            end
            else if (cmd.step && usage_ok && (rec_cnt_reg < REC_CNT_W'(STORE_DEPTH)))
            begin
                rec_reg[rec_cnt_reg] <= cur;
                rec_cnt_reg          <= rec_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    prev_reg[i] <= rec_reg[i];
                end
            end
        end
    end

    // Pending character and output register. A pending character moves out
    // when the next one arrives (not last) or at the end of the scan (last).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.step && sts.emit)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && sts.emit)
        begin
            pend_char_reg  <= cur_char;
            pend_usage_reg <= cur[6:0];
            if (pend_valid_reg)
            begin
                out_char_reg  <= pend_char_reg;
                out_usage_reg <= pend_usage_reg;
                out_last_reg  <= 1'b0;
            end
        end
        else if (cmd.flush)
        begin
            out_char_reg  <= pend_char_reg;
            out_usage_reg <= pend_usage_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign char_code      = out_char_reg;
    assign usage_code     = out_usage_reg;
    assign last_of_report = out_last_reg;

endmodule

>>> design/hid_boot_keyboard_to_ascii.sv
// Top level: HID boot keyboard report to US layout character stream.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   modifier_bits, key_slot_0 .. key_slot_5
//   out      output     out_valid / out_ready char_code, usage_code, last_of_report
//
// One request is scanned one key slot per cycle unless the scan stalls: the
// controller captures the report, scans the KEY_SLOTS slots, then updates the
// previous-key store and releases the last character once the output is free.
// The scan stalls only when a new character is found while one is pending and
// the output register is still full. Each character is held back one step so
// that the final one of a report can carry last_of_report.
// Reset clears the previous-key store, the controller and both valid flags.
// A new request is taken only between reports, but a finished character may
// still wait in the output register while the next request is accepted.
module hid_boot_keyboard_to_ascii (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] modifier_bits,
    input  logic [7:0] key_slot_0,
    input  logic [7:0] key_slot_1,
    input  logic [7:0] key_slot_2,
    input  logic [7:0] key_slot_3,
    input  logic [7:0] key_slot_4,
    input  logic [7:0] key_slot_5,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_code,
    output logic [6:0] usage_code,
    output logic       last_of_report
);
    import hbk_pkg::*;

    hbk_cmd_t cmd;
    hbk_sts_t sts;

    // The controller owns the slot counter and decides when the datapath
    // captures, advances, commits the store and flushes the final character.
    hbk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the captured report, the previous-key store, the
    // layout lookup and the pending and output character registers.
    hbk_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .modifier_bits  (modifier_bits),
        .key_slot_0     (key_slot_0),
        .key_slot_1     (key_slot_1),
        .key_slot_2     (key_slot_2),
        .key_slot_3     (key_slot_3),
        .key_slot_4     (key_slot_4),
        .key_slot_5     (key_slot_5),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .char_code      (char_code),
        .usage_code     (usage_code),
        .last_of_report (last_of_report)
    );

endmodule

>>> bench/keystroke_checker.sv
// Checker that predicts the characters of each accepted keyboard report and compares them.
module keystroke_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] modifier_bits,
    input  logic [7:0] key_slot_0,
    input  logic [7:0] key_slot_1,
    input  logic [7:0] key_slot_2,
    input  logic [7:0] key_slot_3,
    input  logic [7:0] key_slot_4,
    input  logic [7:0] key_slot_5,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] char_code,
    input  logic [6:0] usage_code,
    input  logic       last_of_report,
    output int         mismatches,
    output int         outstanding,
    output int         chars_checked
);
    import hbk_pkg::*;

    // Usage codes that bound the ranges of the US layout.
    localparam byte_t USE_A           = 8'd4;
    localparam byte_t USE_Z           = 8'd29;
    localparam byte_t USE_1           = 8'd30;
    localparam byte_t USE_0           = 8'd39;
    localparam byte_t USE_ENTER       = 8'd40;
    localparam byte_t USE_ESCAPE      = 8'd41;
    localparam byte_t USE_BACKSPACE   = 8'd42;
    localparam byte_t USE_TAB         = 8'd43;
    localparam byte_t USE_SPACEBAR    = 8'd44;
    localparam byte_t USE_MINUS       = 8'd45;
    localparam byte_t USE_NON_US_HASH = 8'd50;
    localparam byte_t USE_SLASH       = 8'd56;
    localparam byte_t USE_KP_STAR     = 8'd85;
    localparam byte_t USE_KP_DOT      = 8'd99;
    localparam byte_t USE_NON_US_BSL  = 8'd100;

    localparam byte_t ASCII_LF        = 8'h0A;
    localparam byte_t ASCII_ESC       = 8'h1B;
    localparam byte_t ASCII_HT        = 8'h09;
    localparam byte_t CHAR_SPACE      = 8'h20;
    localparam byte_t CHAR_SECTION    = 8'hA7;
    localparam byte_t CHAR_PLUS_MINUS = 8'hB1;

    // Character rows, leftmost character in the top byte.
    localparam logic [79:0]  DIGIT_ROW     = "1234567890";
    localparam logic [79:0]  DIGIT_ROW_UP  = "!@#$%^&*()";
    localparam logic [95:0]  SYMBOL_ROW    = {"-=[]\\#;'", 8'h60, ",./"};
    localparam logic [95:0]  SYMBOL_ROW_UP = "_+{}|#:\"~<>?";
    localparam logic [119:0] KEYPAD_ROW    = "*-+\n1234567890.";

    typedef struct packed {
        byte_t      char_code;
        logic [6:0] usage_code;
        logic       last_of_report;
    } key_char_t;

    byte_t     down_keys [STORE_DEPTH];
    key_char_t expected_chars [$];
    key_char_t want;
    int        fail_cnt;
    int        got_cnt;

    function automatic byte_t usage_to_char(input byte_t u, input logic shifted);
        byte_t ch;
        int    i;
        ch = CODE_NONE;
        if (u >= USE_A && u <= USE_Z) begin
            ch = (shifted ? 8'h41 : 8'h61) + (u - USE_A);
        end else if (u >= USE_1 && u <= USE_0) begin
            i  = int'(u - USE_1);
            ch = shifted ? DIGIT_ROW_UP[8*(9-i) +: 8] : DIGIT_ROW[8*(9-i) +: 8];
        end else if (u >= USE_ENTER && u <= USE_SPACEBAR) begin
            case (u)
                USE_ENTER:     ch = ASCII_LF;
                USE_ESCAPE:    ch = ASCII_ESC;
                USE_BACKSPACE: ch = CODE_ERASE;
                USE_TAB:       ch = ASCII_HT;
                default:       ch = CHAR_SPACE;
            endcase
        end else if (u >= USE_MINUS && u <= USE_SLASH) begin
            i = int'(u - USE_MINUS);
            if (u != USE_NON_US_HASH)
                ch = shifted ? SYMBOL_ROW_UP[8*(11-i) +: 8] : SYMBOL_ROW[8*(11-i) +: 8];
        end else if (u >= USE_KP_STAR && u <= USE_KP_DOT) begin
            i  = int'(u - USE_KP_STAR);
            ch = KEYPAD_ROW[8*(14-i) +: 8];
        end else if (u == USE_NON_US_BSL) begin
            ch = shifted ? CHAR_PLUS_MINUS : CHAR_SECTION;
        end
        return ch;
    endfunction

    // Works out the characters of one report and replaces the held-key store.
    task automatic predict_report(input byte_t mods, input logic [8*KEY_SLOTS-1:0] slots);
        byte_t     kept [STORE_DEPTH];
        key_char_t fresh [STORE_DEPTH];
        int        n_kept;
        int        n_fresh;
        logic      shifted;
        logic      held;
        byte_t     u;
        byte_t     ch;
        n_kept  = 0;
        n_fresh = 0;
        shifted = (mods & SHIFT_MASK) != 8'h00;
        for (int k = 0; k < STORE_DEPTH; k++)
            kept[k] = 8'h00;
        for (int s = 0; s < KEY_SLOTS && s < STORE_DEPTH; s++) begin
            u = slots[8*s +: 8];
            if (u != 8'h00 && u < USAGE_LIMIT) begin
                if (n_kept < STORE_DEPTH) begin
                    kept[n_kept] = u;
                    n_kept++;
                end
                held = 1'b0;
                for (int k = 0; k < STORE_DEPTH; k++)
                    if (down_keys[k] == u)
                        held = 1'b1;
                ch = usage_to_char(u, shifted);
                if (!held && ch != CODE_NONE) begin
                    fresh[n_fresh].char_code      = ch;
                    fresh[n_fresh].usage_code     = u[6:0];
                    fresh[n_fresh].last_of_report = 1'b0;
                    n_fresh++;
                end
            end
        end
        for (int i = 0; i < n_fresh; i++) begin
            fresh[i].last_of_report = (i == n_fresh - 1);
            expected_chars.push_back(fresh[i]);
        end
        for (int k = 0; k < STORE_DEPTH; k++)
            down_keys[k] = kept[k];
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++)
                down_keys[k] = 8'h00;
            expected_chars.delete();
            fail_cnt = 0;
            got_cnt  = 0;
            mismatches    <= 0;
            outstanding   <= 0;
            chars_checked <= 0;
        end else begin
            // A character leaving now always belongs to an earlier report.
            if (out_valid && out_ready) begin
                got_cnt++;
                if (expected_chars.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected character: expected none, %s %h usage %0d last %b",
                             $time, "got char", char_code, usage_code, last_of_report);
                end else begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.char_code || usage_code !== want.usage_code ||
                        last_of_report !== want.last_of_report) begin
                        fail_cnt++;
                        $display("%0t: character mismatch: expected char %h usage %0d last %b,",
                                 $time, want.char_code, want.usage_code,
                                 want.last_of_report);
                        $display("    got char %h usage %0d last %b",
                                 char_code, usage_code, last_of_report);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_report(modifier_bits, {key_slot_5, key_slot_4, key_slot_3,
                                               key_slot_2, key_slot_1, key_slot_0});
            mismatches    <= fail_cnt;
            outstanding   <= expected_chars.size();
            chars_checked <= got_cnt;
        end
    end

endmodule

>>> bench/tb_top.sv
// Testbench top: drives keyboard reports and output back-pressure, and gives the verdict.
module tb_top;
    import hbk_pkg::*;

    // Shift bits of the modifier byte, one per side of the keyboard.
    localparam byte_t MOD_LSHIFT     = 8'h02;
    localparam byte_t MOD_RSHIFT     = 8'h20;
    localparam int    RANDOM_REPORTS = 128;
    // Wait after the final drain for any extra character, scaled from KEY_SLOTS.
    localparam int    DRAIN_CYCLES   = 4 * (KEY_SLOTS + 2);
    localparam int    CYCLE_LIMIT    = 300000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] char_code;
    logic [6:0] usage_code;
    logic       last_of_report;

    int mismatches;
    int outstanding;
    int chars_checked;

    int    cycle_count  = 0;
    int    reports_sent = 0;
    int    directed_cnt = 0;
    int    random_sent  = 0;
    int    stall_mode   = 0;
    int    stall_left   = 0;
    // Keys the random typist currently holds down, one per slot.
    byte_t typing_keys [KEY_SLOTS];

    hid_boot_keyboard_to_ascii u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .modifier_bits  (modifier_bits),
        .key_slot_0     (key_slot_0),
        .key_slot_1     (key_slot_1),
        .key_slot_2     (key_slot_2),
        .key_slot_3     (key_slot_3),
        .key_slot_4     (key_slot_4),
        .key_slot_5     (key_slot_5),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .char_code      (char_code),
        .usage_code     (usage_code),
        .last_of_report (last_of_report)
    );

    keystroke_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .modifier_bits  (modifier_bits),
        .key_slot_0     (key_slot_0),
        .key_slot_1     (key_slot_1),
        .key_slot_2     (key_slot_2),
        .key_slot_3     (key_slot_3),
        .key_slot_4     (key_slot_4),
        .key_slot_5     (key_slot_5),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .char_code      (char_code),
        .usage_code     (usage_code),
        .last_of_report (last_of_report),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .chars_checked  (chars_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The watchdog ends a run that hangs, for instance when a character never comes out.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d characters still expected",
                     cycle_count, outstanding);
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver switches at random between stall patterns:
    // always ready, mostly ready, ready one cycle in five, and mostly stalled.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 9) < 7);
            2:       out_ready <= ((cycle_count % 5) == 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Picks a usage, mostly from the mapped ranges of the layout.
    function automatic byte_t pick_usage();
        case ($urandom_range(0, 6))
            0, 1, 2: return 8'($urandom_range(4, 29));
            3:       return 8'($urandom_range(30, 39));
            4:       return 8'($urandom_range(40, 56));
            5:       return 8'($urandom_range(85, 100));
            default: return 8'($urandom_range(1, 100));
        endcase
    endfunction

    // Presents one request and holds it until the block takes it. The valid stays high
    // afterwards unless a gap follows, so back-to-back requests keep the valid high throughout.
    task automatic send_report(input int gap_after, input byte_t mods,
                               input byte_t k0, input byte_t k1, input byte_t k2,
                               input byte_t k3, input byte_t k4, input byte_t k5);
        in_valid      <= 1'b1;
        modifier_bits <= mods;
        key_slot_0    <= k0;
        key_slot_1    <= k1;
        key_slot_2    <= k2;
        key_slot_3    <= k3;
        key_slot_4    <= k4;
        key_slot_5    <= k5;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        reports_sent++;
        if (gap_after > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_after) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every predicted character has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        byte_t mods;
        byte_t keys [KEY_SLOTS];
        int    burst;
        int    gap;
        int    kind;
        int    r;
        logic  no_idle;
        logic  mid_drained;

        mid_drained    = 1'b0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        modifier_bits <= 8'h00;
        key_slot_0    <= 8'h00;
        key_slot_1    <= 8'h00;
        key_slot_2    <= 8'h00;
        key_slot_3    <= 8'h00;
        key_slot_4    <= 8'h00;
        key_slot_5    <= 8'h00;
        for (int s = 0; s < KEY_SLOTS; s++)
            typing_keys[s] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed reports. Usages: 4..29 letters, 30..39 digits, 40..44 control keys,
        // 45..56 punctuation with 50 unmapped, 85..99 keypad, 100 the extra backslash key.
        // An empty report yields nothing.
        send_report($urandom_range(0, 3), 8'h00, 0, 0, 0, 0, 0, 0);
        send_report($urandom_range(0, 3), 8'h00, 4, 0, 0, 0, 0, 0);
        // The same key in another slot is still held, so nothing comes out.
        send_report($urandom_range(0, 3), 8'h00, 0, 0, 4, 0, 0, 0);
        // Left shift: the held key is skipped and the rest come out upper case.
        send_report($urandom_range(0, 3), MOD_LSHIFT, 4, 5, 6, 7, 8, 9);
        send_report($urandom_range(0, 3), MOD_RSHIFT, 30, 31, 32, 33, 34, 35);
        send_report($urandom_range(0, 3), 8'h00, 36, 37, 38, 39, 40, 41);
        // Backspace comes out as the erase code, followed by tab, space and punctuation.
        send_report($urandom_range(0, 3), 8'h00, 42, 43, 44, 45, 46, 47);
        // Both shift bits at once; the unmapped key in the middle is only recorded.
        send_report($urandom_range(0, 3), SHIFT_MASK, 48, 49, 50, 51, 52, 53);
        send_report($urandom_range(0, 3), 8'h00, 54, 55, 56, 85, 86, 87);
        send_report($urandom_range(0, 3), 8'h00, 88, 89, 90, 91, 92, 93);
        send_report($urandom_range(0, 3), 8'h00, 94, 95, 96, 97, 98, 99);
        // The top usage, unshifted, then released and pressed again with shift.
        send_report($urandom_range(0, 3), 8'h00, 100, 0, 0, 0, 0, 0);
        send_report($urandom_range(0, 3), 8'h00, 0, 0, 0, 0, 0, 0);
        send_report($urandom_range(0, 3), MOD_LSHIFT, 100, 0, 0, 0, 0, 0);
        // Out-of-range and unmapped usages with many modifier bits but no shift bit.
        send_report($urandom_range(0, 3), 8'hDD, 101, 255, 1, 2, 3, 57);
        send_report($urandom_range(0, 3), 8'h00, 84, 2, 3, 57, 101, 255);
        // A new key repeated in several slots yields one character per slot.
        send_report($urandom_range(0, 3), 8'h00, 20, 20, 20, 0, 20, 20);
        send_report($urandom_range(0, 3), 8'h00, 20, 20, 20, 20, 20, 20);
        // Every modifier bit set and six new characters: the most one report can give.
        send_report(0, 8'hFF, 29, 29, 29, 29, 29, 29);
        send_report(0, 8'hFF, 255, 255, 255, 255, 255, 255);
        send_report($urandom_range(0, 3), 8'hDD, 11, 12, 0, 0, 0, 0);
        send_report($urandom_range(0, 3), 8'h00, 0, 0, 0, 0, 0, 0);
        directed_cnt = reports_sent;
        drain_results();

        // Random reports in bursts. Most follow a typist who keeps, releases and presses
        // keys from one report to the next, so held keys and new keys mix. The rest are
        // raw bytes in every field, or reports full of out-of-range, unmapped and
        // repeated usages. A stretch in the middle sends without any gap.
        while (random_sent < RANDOM_REPORTS)
        begin
            burst   = $urandom_range(1, 8);
            no_idle = (random_sent >= 50 && random_sent < 80);
            for (int b = 0; b < burst; b++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 65)
                begin
                    r = $urandom_range(0, 3);
                    case (r)
                        0:       mods = 8'h00;
                        1:       mods = MOD_LSHIFT;
                        2:       mods = MOD_RSHIFT;
                        default: mods = 8'($urandom_range(0, 255));
                    endcase
                    for (int s = 0; s < KEY_SLOTS; s++)
                    begin
                        r = $urandom_range(0, 9);
                        if (r >= 6)
                            typing_keys[s] = pick_usage();
                        else if (r >= 4)
                            typing_keys[s] = 8'h00;
                        keys[s] = typing_keys[s];
                    end
                end
                else if (kind < 85)
                begin
                    mods = 8'($urandom_range(0, 255));
                    for (int s = 0; s < KEY_SLOTS; s++)
                        keys[s] = 8'($urandom_range(0, 255));
                end
                else
                begin
                    mods = 8'($urandom_range(0, 255));
                    for (int s = 0; s < KEY_SLOTS; s++)
                    begin
                        case ($urandom_range(0, 4))
                            0:       keys[s] = 8'h00;
                            1:       keys[s] = 8'($urandom_range(101, 255));
                            2:       keys[s] = 8'($urandom_range(1, 3));
                            3:       keys[s] = 8'($urandom_range(57, 84));
                            default: keys[s] = typing_keys[$urandom_range(0, KEY_SLOTS - 1)];
                        endcase
                    end
                end
                gap = (b == burst - 1 && !no_idle) ? $urandom_range(0, 12) : 0;
                send_report(gap, mods, keys[0], keys[1], keys[2], keys[3], keys[4], keys[5]);
                random_sent++;
            end
            // Once in the middle the sender holds off until the output side is empty.
            if (random_sent >= 100 && !mid_drained)
            begin
                drain_results();
                mid_drained = 1'b1;
            end
        end

        // Let the last characters drain, then give the block time to show any extra one.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d keyboard reports (%0d directed, %0d random), checked %0d characters.",
                 reports_sent, directed_cnt, random_sent, chars_checked);
        $display("Covered plain and shifted keys, held and repeated keys, %s",
                 "unmapped and out-of-range usages, and output stalls.");
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
